// File: src/llba_pkg.sv
// ----------------------------------------------------------------------------
// llba_pkg: shared types and constants of the least loaded bin assigner
// Field widths, register indexes and load limits used by the interfaces,
// the top level and the checker.
// ----------------------------------------------------------------------------
package llba_pkg;

    localparam int TAG_W       = 16;
    localparam int BIN_W       = 7;
    localparam int LOAD_W      = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    typedef logic [TAG_W-1:0]       tag_t;
    typedef logic [BIN_W-1:0]       bin_t;
    typedef logic [LOAD_W-1:0]      load_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    localparam cfg_index_t REG_BINS_IN_USE = cfg_index_t'(0);
    localparam cfg_index_t REG_MAX_SPREAD  = cfg_index_t'(1);

    localparam bin_t  BINS_RESET   = bin_t'(1);
    localparam load_t SPREAD_RESET = '0;
    localparam load_t LOAD_TOP     = '1;

endpackage

// File: src/llba_ifs.sv
// ----------------------------------------------------------------------------
// llba_ifs: channel interfaces of the least loaded bin assigner
// Item input, result output and configuration write channels, each with a
// valid/ready handshake and source and sink modports.
// ----------------------------------------------------------------------------
interface llba_in_if #(
    parameter int SIZE_BITS = 16
);
    import llba_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SIZE_BITS-1:0] item_size;
    tag_t                 item_tag;
    logic                 last_item;

    modport source (output valid, output item_size, output item_tag, output last_item,
                    input ready);
    modport sink   (input valid, input item_size, input item_tag, input last_item,
                    output ready);
endinterface

interface llba_out_if;
    import llba_pkg::*;

    logic  valid;
    logic  ready;
    bin_t  bin_number;
    tag_t  tag_out;
    logic  verdict_valid;
    logic  balanced;
    load_t load_spread;

    modport source (output valid, output bin_number, output tag_out, output verdict_valid,
                    output balanced, output load_spread, input ready);
    modport sink   (input valid, input bin_number, input tag_out, input verdict_valid,
                    input balanced, input load_spread, output ready);
endinterface

interface llba_cfg_if;
    import llba_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/least_loaded_bin_assigner_top.sv
// ----------------------------------------------------------------------------
// least_loaded_bin_assigner_top: greedy least loaded bin assignment
// Bin loads live in one synchronous RAM that is scanned once per item to
// find the least loaded bin and, on the last item of a set, the load spread.
// ----------------------------------------------------------------------------
// The RAM read port scans one bin per cycle over the first k bins of an item,
// where k is the clamped bins_in_use. Items are taken one at a time, and a
// last item adds a clearing pass over the RAM before the next is accepted.
// Configuration writes are always accepted.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes all
// MAX_BINS RAM entries while no item is accepted.
module least_loaded_bin_assigner_top #(
    parameter int MAX_BINS  = 64,
    parameter int SIZE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    llba_in_if.sink    items,
    llba_out_if.source results,
    llba_cfg_if.sink   cfg
);
    import llba_pkg::*;

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int KW = $clog2(MAX_BINS + 1);
    localparam logic [KW-1:0] K_MAX = KW'(MAX_BINS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // Control registers.
    logic [2:0]    state_reg, state_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic          rd_valid_reg, rd_valid_next;
    logic          out_valid_reg, out_valid_next;
    bin_t          bins_reg, bins_next;
    load_t         spread_lim_reg, spread_lim_next;

    // Payload registers.
    logic [KW-1:0]        k_reg, k_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    tag_t                 tag_reg, tag_next;
    logic                 last_reg, last_next;
    logic [AW-1:0]        rd_idx_reg, rd_idx_next;
    load_t                min1_reg, min1_next;
    load_t                min2_reg, min2_next;
    load_t                max_reg, max_next;
    logic [AW-1:0]        best_reg, best_next;
    load_t                new_load_reg, new_load_next;
    load_t                hi_reg, hi_next;
    load_t                lo_reg, lo_next;
    bin_t                 bin_out_reg, bin_out_next;
    tag_t                 tag_out_reg, tag_out_next;
    logic                 verdict_reg, verdict_next;
    logic                 balanced_reg, balanced_next;
    load_t                spread_out_reg, spread_out_next;

    // Load RAM.
    load_t         mem [MAX_BINS];
    load_t         rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    load_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic [31:0]   bins_ext;
    logic [KW-1:0] k_clamped;
    logic [KW-1:0] k_last;
    logic [32:0]   sum;
    load_t         spread;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign items.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;

    assign results.valid         = out_valid_reg;
    assign results.bin_number    = bin_out_reg;
    assign results.tag_out       = tag_out_reg;
    assign results.verdict_valid = verdict_reg;
    assign results.balanced      = balanced_reg;
    assign results.load_spread   = spread_out_reg;

    always_comb
    begin
        bins_ext = 32'(bins_reg);
        if (bins_ext == 32'd0)
        begin
            k_clamped = KW'(1);
        end
        else if (bins_ext > 32'(MAX_BINS))
        begin
            k_clamped = K_MAX;
        end
        else
        begin
            k_clamped = KW'(bins_ext);
        end
    end

    assign k_last = k_reg - KW'(1);
    assign sum    = {1'b0, min1_reg} + 33'(size_reg);
    assign spread = hi_reg - lo_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_valid_next   = 1'b0;
        out_valid_next  = out_valid_reg;
        bins_next       = bins_reg;
        spread_lim_next = spread_lim_reg;

        k_next          = k_reg;
        size_next       = size_reg;
        tag_next        = tag_reg;
        last_next       = last_reg;
        rd_idx_next     = rd_idx_reg;
        min1_next       = min1_reg;
        min2_next       = min2_reg;
        max_next        = max_reg;
        best_next       = best_reg;
        new_load_next   = new_load_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        bin_out_next    = bin_out_reg;
        tag_out_next    = tag_out_reg;
        verdict_next    = verdict_reg;
        balanced_next   = balanced_reg;
        spread_out_next = spread_out_reg;

        mem_we    = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = cnt_reg[AW-1:0];

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid)
        begin
            case (cfg.index)
                REG_BINS_IN_USE: bins_next = cfg.data[BIN_W-1:0];
                REG_MAX_SPREAD:  spread_lim_next = cfg.data[LOAD_W-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[AW-1:0];
                mem_wdata = '0;
                if (cnt_reg == K_MAX - KW'(1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + KW'(1);
                end
            end
            ST_IDLE:
            begin
                if (items.valid)
                begin
                    size_next  = items.item_size;
                    tag_next   = items.item_tag;
                    last_next  = items.last_item;
                    k_next     = k_clamped;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg < k_reg)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = cnt_reg[AW-1:0];
                    rd_valid_next = 1'b1;
                    rd_idx_next   = cnt_reg[AW-1:0];
                    cnt_next      = cnt_reg + KW'(1);
                end
                if (rd_valid_reg)
                begin
                    // min2 tracks the smallest load among the bins other than
                    // the current best, for the spread after the update.
                    if (rd_idx_reg == '0)
                    begin
                        min1_next = rd_data_reg;
                        min2_next = LOAD_TOP;
                        max_next  = rd_data_reg;
                        best_next = '0;
                    end
                    else
                    begin
                        if (rd_data_reg < min1_reg)
                        begin
                            min2_next = min1_reg;
                            min1_next = rd_data_reg;
                            best_next = rd_idx_reg;
                        end
                        else if (rd_data_reg < min2_reg)
                        begin
                            min2_next = rd_data_reg;
                        end
                        if (rd_data_reg > max_reg)
                        begin
                            max_next = rd_data_reg;
                        end
                    end
                    if (KW'(rd_idx_reg) == k_last)
                    begin
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                new_load_next = sum[32] ? LOAD_TOP : sum[LOAD_W-1:0];
                state_next    = ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = best_reg;
                mem_wdata = new_load_reg;
                hi_next   = (max_reg > new_load_reg) ? max_reg : new_load_reg;
                lo_next   = (min2_reg < new_load_reg) ? min2_reg : new_load_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next  = 1'b1;
                    bin_out_next    = BIN_W'(32'(best_reg) + 32'd1);
                    tag_out_next    = tag_reg;
                    verdict_next    = last_reg;
                    balanced_next   = last_reg && (spread <= spread_lim_reg);
                    spread_out_next = last_reg ? spread : '0;
                    cnt_next        = '0;
                    state_next      = last_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                cnt_next   = '0;
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            bins_reg       <= BINS_RESET;
            spread_lim_reg <= SPREAD_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_valid_reg   <= rd_valid_next;
            out_valid_reg  <= out_valid_next;
            bins_reg       <= bins_next;
            spread_lim_reg <= spread_lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        size_reg       <= size_next;
        tag_reg        <= tag_next;
        last_reg       <= last_next;
        rd_idx_reg     <= rd_idx_next;
        min1_reg       <= min1_next;
        min2_reg       <= min2_next;
        max_reg        <= max_next;
        best_reg       <= best_next;
        new_load_reg   <= new_load_next;
        hi_reg         <= hi_next;
        lo_reg         <= lo_next;
        bin_out_reg    <= bin_out_next;
        tag_out_reg    <= tag_out_next;
        verdict_reg    <= verdict_next;
        balanced_reg   <= balanced_next;
        spread_out_reg <= spread_out_next;
    end

endmodule

// File: src/llba_checker.sv
// ----------------------------------------------------------------------------
// llba_checker: port level checks of the least loaded bin assigner
// Watches the item and result channels of the top level over time.
// ----------------------------------------------------------------------------
module llba_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input llba_pkg::bin_t  bin_number,
    input llba_pkg::tag_t  tag_out,
    input logic           verdict_valid,
    input logic           balanced,
    input llba_pkg::load_t load_spread
);
    import llba_pkg::*;

    // A stalled result holds and keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin_number) && $stable(tag_out)
            && $stable(verdict_valid) && $stable(balanced) && $stable(load_spread))
    else $error("stalled result changed");

    // A result that does not close a set carries no verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !verdict_valid |-> !balanced && (load_spread == '0))
    else $error("verdict fields set on a result that does not close a set");

    // Bins are numbered from one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bin_number != '0)
    else $error("bin number zero");

    // Items are worked on one at a time, so a transaction drops ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("ready held after an accepted item");

endmodule

bind least_loaded_bin_assigner_top llba_checker u_llba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (items.valid),
    .in_ready      (items.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .bin_number    (results.bin_number),
    .tag_out       (results.tag_out),
    .verdict_valid (results.verdict_valid),
    .balanced      (results.balanced),
    .load_spread   (results.load_spread)
);
